FILE: rtl/htalf_pkg.sv
`timescale 1ns / 1ps

package htalf_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

endpackage

FILE: rtl/handle_table_alloc_lookup_free.sv
`timescale 1ns / 1ps

// Channel   | Ports                         | Handshake
// ----------+-------------------------------+----------------------------------
// request   | command, handle_key           | taken when start && !busy
// result    | status, slot_index            | one-cycle strobe on done
//
// Each request scans every slot of the key memory, one read per cycle,
// as the key memory has a single read port.
// Reset clears all valid bits at once; no clearing pass is needed.
// Busy stays high from acceptance through the cycle in which done is driven,
// and a new request may be taken in the cycle after done.
// The receiver cannot stall; each result is shown for exactly one cycle.

module handle_table_alloc_lookup_free (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] handle_key,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  slot_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    localparam int SW = htalf_pkg::SLOT_W;
    localparam int CW = htalf_pkg::CNT_W;

    state_t state_reg;
    state_t state_next;

    logic [31:0] key_mem [htalf_pkg::TABLE_SLOTS];
    logic [31:0] rd_data_reg;

    logic [htalf_pkg::TABLE_SLOTS-1:0] valid_reg;
    logic [htalf_pkg::TABLE_SLOTS-1:0] valid_next;

    logic [1:0]    cmd_reg;
    logic [31:0]   key_reg;
    logic [CW-1:0] issue_reg;
    logic          pend_reg;
    logic [SW-1:0] pend_idx_reg;
    logic          match_reg;
    logic [SW-1:0] match_idx_reg;
    logic          free_reg;
    logic [SW-1:0] free_idx_reg;

    logic          done_reg;
    logic [1:0]    status_reg;
    logic [3:0]    slot_index_reg;

    logic          accept;
    logic          issue_live;
    logic          hit;
    logic          empty_slot;
    logic          scan_end;
    logic          wr_en;
    logic [1:0]    res_status;
    logic [SW-1:0] res_idx;
    logic [SW+3:0] res_idx_ext;

    assign accept     = start && (state_reg == S_IDLE);
    assign issue_live = issue_reg < CW'(htalf_pkg::TABLE_SLOTS);
    assign hit        = pend_reg && valid_reg[pend_idx_reg] && (rd_data_reg == key_reg);
    assign empty_slot = pend_reg && !valid_reg[pend_idx_reg];
    assign scan_end   = (state_reg == S_SCAN) && !issue_live && !pend_reg;

    always_comb
    begin
        res_status = htalf_pkg::ST_MISSING;
        res_idx    = '0;
        valid_next = valid_reg;
        wr_en      = 1'b0;
        unique case (cmd_reg) inside
            htalf_pkg::CMD_ALLOC:
            begin
                if (match_reg)
                begin
                    res_status = htalf_pkg::ST_DUP;
                end
                else if (!free_reg)
                begin
                    res_status = htalf_pkg::ST_FULL;
                end
                else
                begin
                    res_status = htalf_pkg::ST_OK;
                    res_idx    = free_idx_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    wr_en      = scan_end;
                end
            end
            htalf_pkg::CMD_LOOKUP, htalf_pkg::CMD_FREE:
            begin
                if (match_reg)
                begin
                    res_status = htalf_pkg::ST_OK;
                    res_idx    = match_idx_reg;
                    if (cmd_reg == htalf_pkg::CMD_FREE)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                    end
                end
            end
            default:
            begin
                res_status = htalf_pkg::ST_MISSING;
            end
        endcase
        res_idx_ext = {4'b0000, res_idx};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[free_idx_reg] <= key_reg;
        end
        rd_data_reg <= key_mem[issue_reg[SW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
            done_reg       <= 1'b0;
            issue_reg      <= '0;
            cmd_reg        <= '0;
            key_reg        <= '0;
            pend_idx_reg   <= '0;
            match_idx_reg  <= '0;
            free_idx_reg   <= '0;
            status_reg     <= '0;
            slot_index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            if (accept)
            begin
                cmd_reg   <= command;
                key_reg   <= handle_key;
                issue_reg <= '0;
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                if (issue_live)
                begin
                    pend_reg     <= 1'b1;
                    pend_idx_reg <= issue_reg[SW-1:0];
                    issue_reg    <= issue_reg + CW'(1);
                end
                if (hit && !match_reg)
                begin
                    match_reg     <= 1'b1;
                    match_idx_reg <= pend_idx_reg;
                end
                if (empty_slot && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= pend_idx_reg;
                end
                if (scan_end)
                begin
                    valid_reg      <= valid_next;
                    done_reg       <= 1'b1;
                    status_reg     <= res_status;
                    slot_index_reg <= res_idx_ext[3:0];
                end
            end
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_index_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != htalf_pkg::ST_OK) |-> (slot_index_reg == 4'd0))
        else $error("slot index nonzero on a failed request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done_reg)
        else $error("accepted request did not raise busy");

    a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
        scan_end && (cmd_reg == htalf_pkg::CMD_ALLOC) && (res_status == htalf_pkg::ST_OK)
        |=> valid_reg[$past(free_idx_reg)])
        else $error("allocated slot not marked valid");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> busy)
        else $error("result strobe outside a busy request");

endmodule
